@@ hdl/rmu_pkg.sv @@
`timescale 1ns / 1ps

package rmu_pkg;

    localparam int Capacity   = 1024;
    localparam int HeapDepth  = (Capacity + 1) / 2;
    localparam int AddrBits   = $clog2(HeapDepth);
    localparam int CntBits    = $clog2(HeapDepth + 1);
    localparam int ValueBits  = 16;
    localparam int MedianBits = ValueBits + 1;

    typedef logic [ValueBits-1:0] t_value;
    typedef logic [AddrBits-1:0]  t_addr;
    typedef logic [CntBits-1:0]   t_cnt;

    // One request to the shared heap-order comparator.
    typedef struct packed {
        t_value a;
        t_value b;
        logic   is_max;
    } t_cmp_req;

endpackage

@@ hdl/rmu_ram.sv @@
`timescale 1ns / 1ps

module rmu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/rmu_cmp.sv @@
`timescale 1ns / 1ps

module rmu_cmp (
    input  rmu_pkg::t_cmp_req i_req,
    output logic              o_before
);
    import rmu_pkg::*;

    // True when a belongs above b: larger in a max-heap, smaller in a min-heap.
    assign o_before = i_req.is_max ? (i_req.a > i_req.b) : (i_req.a < i_req.b);

endmodule

@@ hdl/running_median_unit.sv @@
`timescale 1ns / 1ps
// A dropped value goes straight to the finish step. A stored value rises through its heap
// one level per compare step. A replaced top then sinks through the other heap, and the
// finish step loads the result register once any result still held there is taken.
// Sift steps take turns on the single read port and comparator; each heap has 512 entries.
// o_ready returns as the result loads, so a new item is taken only once the last is done.
// Reset (synchronous, active low) empties both heaps by clearing the counts.

module running_median_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [15:0]                i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [16:0]                o_median_x2,
    output logic                       o_dropped
);
    import rmu_pkg::*;

    // The sequencer walks one heap at a time with a "hole" method: the moving value
    // is kept in r_val and entries are shifted into the hole, which yields the same
    // array as repeated swaps.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_DOWN_CHK,
        S_DOWN_L,
        S_DOWN_R,
        S_DOWN_DEC,
        S_FINISH
    } t_state;

    t_state   r_state;
    logic     r_sel;        // 1: lower (max) heap, 0: upper (min) heap
    t_value   r_val;
    t_value   r_newv;
    logic     r_do_rep;
    t_addr    r_idx;
    t_value   r_best_val;
    t_addr    r_best_idx;
    logic     r_best_moved;
    logic     r_drop;
    t_cnt     r_lcnt;
    t_cnt     r_ucnt;
    t_value   r_ltop;
    t_value   r_utop;
    logic     r_out_valid;
    logic [MedianBits-1:0] r_median;
    logic     r_out_drop;

    logic                 w_we;
    t_addr                w_waddr;
    t_value               w_wdata;
    t_addr                w_raddr;
    t_value               w_lrd;
    t_value               w_urd;
    t_value               w_rd;
    t_cmp_req             w_req;
    logic                 w_before;
    t_cnt                 w_cnt;
    t_addr                w_parent;
    logic [CntBits:0]     w_left;
    logic [CntBits:0]     w_right;
    logic [CntBits:0]     w_total;
    logic [MedianBits-1:0] w_median;

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_median_x2 = r_median;
    assign o_dropped   = r_out_drop;

    assign w_rd     = r_sel ? w_lrd : w_urd;
    assign w_cnt    = r_sel ? r_lcnt : r_ucnt;
    assign w_parent = (r_idx - t_addr'(1)) >> 1;
    assign w_left   = {{(CntBits - AddrBits){1'b0}}, r_idx, 1'b1};
    assign w_right  = w_left + (CntBits + 1)'(1);
    assign w_total  = {1'b0, r_lcnt} + {1'b0, r_ucnt};

    // Median from the cached tops; the lower heap is never smaller than the upper.
    always_comb begin
        if (r_lcnt == '0) begin
            w_median = '0;
        end else if (r_lcnt == r_ucnt) begin
            w_median = {1'b0, r_ltop} + {1'b0, r_utop};
        end else begin
            w_median = {r_ltop, 1'b0};
        end
    end

    // Comparator operands depend on the step of the sift.
    always_comb begin
        w_req.is_max = r_sel;
        w_req.a      = w_rd;
        w_req.b      = r_val;
        case (r_state)
            S_PUSH_CMP: begin
                w_req.a = r_val;
                w_req.b = w_rd;
            end
            S_DOWN_R: begin
                w_req.b = r_best_val;
            end
            default: begin
            end
        endcase
    end

    // Write port and read address of the active heap.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_val;
        w_raddr = w_parent;
        unique case (r_state)
            S_PUSH_CHK: begin
                w_we = (r_idx == '0);
            end
            S_PUSH_CMP: begin
                w_we = 1'b1;
                if (w_before) begin
                    w_wdata = w_rd;
                end
            end
            S_DOWN_CHK: begin
                w_raddr = w_left[AddrBits-1:0];
                w_we    = (w_left >= {1'b0, w_cnt});
            end
            S_DOWN_L: begin
                w_raddr = w_right[AddrBits-1:0];
            end
            S_DOWN_DEC: begin
                w_we = 1'b1;
                if (r_best_moved) begin
                    w_wdata = r_best_val;
                end
            end
            default: begin
            end
        endcase
    end

    rmu_cmp u_cmp (
        .i_req    (w_req),
        .o_before (w_before)
    );

    rmu_ram #(.WIDTH(ValueBits), .DEPTH(HeapDepth)) u_lower (
        .i_clk   (i_clk),
        .i_we    (w_we & r_sel),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_lrd)
    );

    rmu_ram #(.WIDTH(ValueBits), .DEPTH(HeapDepth)) u_upper (
        .i_clk   (i_clk),
        .i_we    (w_we & ~r_sel),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_urd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lcnt      <= '0;
            r_ucnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Keep the heap tops in registers so the median needs no RAM read.
            if (w_we && w_waddr == '0) begin
                if (r_sel) begin
                    r_ltop <= w_wdata;
                end else begin
                    r_utop <= w_wdata;
                end
            end
            // The finish step loads the output register itself.
            if (r_out_valid && i_ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_newv <= i_value;
                        if (w_total >= (CntBits + 1)'(Capacity)) begin
                            r_do_rep <= 1'b0;
                            r_val    <= i_value;
                            r_drop   <= 1'b1;
                            r_state  <= S_FINISH;
                        end else begin
                            r_drop  <= 1'b0;
                            r_state <= S_PUSH_CHK;
                            if (r_lcnt == r_ucnt) begin
                                // Push to the lower heap, trading with the upper
                                // top when the new value belongs above it.
                                r_sel  <= 1'b1;
                                r_idx  <= r_lcnt[AddrBits-1:0];
                                r_lcnt <= r_lcnt + t_cnt'(1);
                                if (r_ucnt != '0 && i_value > r_utop) begin
                                    r_val    <= r_utop;
                                    r_do_rep <= 1'b1;
                                end else begin
                                    r_val    <= i_value;
                                    r_do_rep <= 1'b0;
                                end
                            end else begin
                                r_sel  <= 1'b0;
                                r_idx  <= r_ucnt[AddrBits-1:0];
                                r_ucnt <= r_ucnt + t_cnt'(1);
                                if (r_lcnt != '0 && i_value < r_ltop) begin
                                    r_val    <= r_ltop;
                                    r_do_rep <= 1'b1;
                                end else begin
                                    r_val    <= i_value;
                                    r_do_rep <= 1'b0;
                                end
                            end
                        end
                    end
                end
                S_PUSH_CHK: begin
                    if (r_idx == '0) begin
                        r_state <= r_do_rep ? S_DOWN_CHK : S_FINISH;
                        if (r_do_rep) begin
                            r_sel    <= ~r_sel;
                            r_val    <= r_newv;
                            r_do_rep <= 1'b0;
                        end
                    end else begin
                        r_state <= S_PUSH_CMP;
                    end
                end
                S_PUSH_CMP: begin
                    if (w_before) begin
                        r_idx   <= w_parent;
                        r_state <= S_PUSH_CHK;
                    end else begin
                        r_state <= r_do_rep ? S_DOWN_CHK : S_FINISH;
                        if (r_do_rep) begin
                            r_sel    <= ~r_sel;
                            r_idx    <= '0;
                            r_val    <= r_newv;
                            r_do_rep <= 1'b0;
                        end
                    end
                end
                S_DOWN_CHK: begin
                    r_state <= (w_left >= {1'b0, w_cnt}) ? S_FINISH : S_DOWN_L;
                end
                S_DOWN_L: begin
                    r_best_moved <= w_before;
                    r_best_val   <= w_before ? w_rd : r_val;
                    r_best_idx   <= w_left[AddrBits-1:0];
                    r_state      <= (w_right < {1'b0, w_cnt}) ? S_DOWN_R : S_DOWN_DEC;
                end
                S_DOWN_R: begin
                    if (w_before) begin
                        r_best_moved <= 1'b1;
                        r_best_val   <= w_rd;
                        r_best_idx   <= w_right[AddrBits-1:0];
                    end
                    r_state <= S_DOWN_DEC;
                end
                S_DOWN_DEC: begin
                    if (r_best_moved) begin
                        r_idx   <= r_best_idx;
                        r_state <= S_DOWN_CHK;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_median    <= w_median;
                        r_out_drop  <= r_drop;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The lower heap holds as many entries as the upper one, or one more.
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcnt == r_ucnt) || (r_lcnt == r_ucnt + t_cnt'(1)))
        else $error("heap counts out of balance");

    // A dropped value is reported only when the store is full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (w_total == (CntBits + 1)'(Capacity)))
        else $error("drop reported with room in the store");

    // An accepted value that is stored raises the total by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && w_total < (CntBits + 1)'(Capacity))
        |=> (w_total == $past(w_total) + (CntBits + 1)'(1)))
        else $error("count did not advance on insert");

endmodule
